>>> rtl/hpr_pkg.sv
// Package for the histogram plot renderer: function codes, the command
// that travels from the front part to the back part, and fixed widths.
// No dependencies; hpr_front, hpr_back, the top level and the testbench import it.
`default_nettype none

package hpr_pkg;

  localparam int unsigned NUM_BINS = 256;
  localparam int unsigned BIN_W    = 8;
  localparam int unsigned HEIGHT_W = 8;

  localparam logic [HEIGHT_W-1:0] BAR_SCALE   = 8'd250;
  localparam logic [BIN_W-1:0]    PLOT_BOTTOM = 8'd255;

  localparam logic [1:0] FUNC_ACCUM = 2'd0;
  localparam logic [1:0] FUNC_READ  = 2'd1;
  localparam logic [1:0] FUNC_CLEAR = 2'd2;

  typedef enum logic [1:0] {
    OP_ACCUM = 2'd0,
    OP_READ  = 2'd1,
    OP_CLEAR = 2'd2,
    OP_NONE  = 2'd3
  } op_e;

  typedef struct packed {
    op_e              op;
    logic [BIN_W-1:0] addr;
    logic [BIN_W-1:0] row;
  } cmd_t;

  function automatic op_e classify(input logic [1:0] func);
    op_e op;
    case (func)
      FUNC_ACCUM: op = OP_ACCUM;
      FUNC_READ:  op = OP_READ;
      FUNC_CLEAR: op = OP_CLEAR;
      default:    op = OP_NONE;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

>>> rtl/hpr_in_if.sv
// Input channel of the histogram plot renderer: valid/ready plus one item.
// Depends on nothing.
`default_nettype none

interface hpr_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] func;
  logic [7:0] pixel_value;
  logic [7:0] plot_row;
  logic [7:0] plot_col;

  modport source (output valid, func, pixel_value, plot_row, plot_col, input ready);
  modport sink   (input valid, func, pixel_value, plot_row, plot_col, output ready);
endinterface

`default_nettype wire

>>> rtl/hpr_out_if.sv
// Output channel of the histogram plot renderer: valid/ready plus one result.
// Depends on nothing.
`default_nettype none

interface hpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] plot_pixel;
  logic [7:0] bar_height;

  modport source (output valid, plot_pixel, bar_height, input ready);
  modport sink   (input valid, plot_pixel, bar_height, output ready);
endinterface

`default_nettype wire

>>> rtl/hpr_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
`default_nettype none

module hpr_ram #(
  parameter int unsigned WIDTH = 21,
  parameter int unsigned DEPTH = 256
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

>>> rtl/hpr_front.sv
// Front part: accepts input beats, classifies the function code and holds
// the commands in a two-entry queue for the back part.
// Depends on hpr_pkg and hpr_in_if.
`default_nettype none

module hpr_front (
  input  wire logic   clk_i,
  input  wire logic   rst_ni,
  hpr_in_if.sink      in_i,
  output hpr_pkg::cmd_t cmd_o,
  output logic        cmd_valid_o,
  input  wire logic   cmd_pop_i
);
  import hpr_pkg::*;

  localparam int unsigned QueueDepth = 2;
  localparam int unsigned PtrW       = $clog2(QueueDepth);
  localparam int unsigned CntW       = $clog2(QueueDepth + 1);

  cmd_t            slot_q [QueueDepth];
  logic [PtrW-1:0] wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0] rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0] count_q, count_d;
  logic            push, pop;
  cmd_t            cmd_in;

  assign in_i.ready  = (count_q != CntW'(QueueDepth));
  assign push        = in_i.valid && in_i.ready;
  assign cmd_valid_o = (count_q != '0);
  assign pop         = cmd_pop_i && cmd_valid_o;
  assign cmd_o       = slot_q[rd_ptr_q];

  // An accumulate addresses the bin of the pixel, a read the bin of the column.
  always_comb begin
    cmd_in.op   = classify(in_i.func);
    cmd_in.addr = (cmd_in.op == OP_ACCUM) ? in_i.pixel_value : in_i.plot_col;
    cmd_in.row  = in_i.plot_row;
  end

  always_comb begin
    wr_ptr_d = push ? wr_ptr_q + PtrW'(1) : wr_ptr_q;
    rd_ptr_d = pop  ? rd_ptr_q + PtrW'(1) : rd_ptr_q;
    count_d  = count_q;
    if (push && !pop) begin
      count_d = count_q + CntW'(1);
    end else if (pop && !push) begin
      count_d = count_q - CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      slot_q[wr_ptr_q] <= cmd_in;
    end
  end

endmodule

`default_nettype wire

>>> rtl/hpr_back.sv
// Back part: runs one command at a time against the bin RAM, divides for the
// bar height one quotient bit per cycle and drives the output register.
// Depends on hpr_pkg, hpr_ram and hpr_out_if.
`default_nettype none

module hpr_back #(
  parameter int unsigned COUNT_BITS = 21
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire hpr_pkg::cmd_t cmd_i,
  input  wire logic          cmd_valid_i,
  output logic               cmd_pop_o,
  input  wire logic          cfg_we_i,
  input  wire logic [7:0]    cfg_wdata_i,
  hpr_out_if.source          out_o
);
  import hpr_pkg::*;

  localparam int unsigned ProdW = COUNT_BITS + HEIGHT_W;
  localparam int unsigned StepW = $clog2(HEIGHT_W);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_LOOK = 5'b00010,
    ST_PREP = 5'b00100,
    ST_DIV  = 5'b01000,
    ST_DONE = 5'b10000
  } state_e;

  state_e                 state_q, state_d;
  logic [NUM_BINS-1:0]    valid_q, valid_d;
  logic [COUNT_BITS-1:0]  max_q, max_d;
  logic [7:0]             bg_q;
  op_e                    op_q, op_d;
  logic [BIN_W-1:0]       addr_q, addr_d;
  logic [BIN_W-1:0]       row_q, row_d;
  logic                   hit_q, hit_d;
  logic [ProdW-1:0]       prod_q, prod_d;
  logic [COUNT_BITS-1:0]  rem_q, rem_d;
  logic [HEIGHT_W-1:0]    quo_q, quo_d;
  logic [StepW-1:0]       step_q, step_d;
  logic                   out_valid_q, out_valid_d;
  logic [7:0]             out_pixel_q, out_pixel_d;
  logic [HEIGHT_W-1:0]    out_height_q, out_height_d;

  logic                   ram_re, ram_we;
  logic [COUNT_BITS-1:0]  ram_rdata;
  logic [COUNT_BITS-1:0]  cnt, cnt_inc;
  logic [COUNT_BITS:0]    rem_sh, rem_diff;
  logic                   rem_ge;
  logic [HEIGHT_W-1:0]    height;
  logic                   bar;
  logic                   load_out;

  hpr_ram #(
    .WIDTH (COUNT_BITS),
    .DEPTH (NUM_BINS)
  ) u_bins (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (addr_q),
    .wdata_i (cnt_inc),
    .re_i    (ram_re),
    .raddr_i (cmd_i.addr),
    .rdata_o (ram_rdata)
  );

  // A bin not written since the last clear reads as zero.
  assign cnt     = hit_q ? ram_rdata : '0;
  assign cnt_inc = (cnt == {COUNT_BITS{1'b1}}) ? cnt : cnt + COUNT_BITS'(1);

  // Restoring division: the remainder always stays below the largest count,
  // since no bin exceeds it, so eight steps give the whole quotient.
  assign rem_sh   = {rem_q, quo_q[HEIGHT_W-1]};
  assign rem_ge   = (rem_sh >= {1'b0, max_q});
  assign rem_diff = rem_sh - {1'b0, max_q};

  assign height   = (op_q == OP_READ) ? quo_q : '0;
  assign bar      = (height != '0) && (row_q >= (PLOT_BOTTOM - height));
  assign load_out = (state_q == ST_DONE) && (!out_valid_q || out_o.ready);

  assign cmd_pop_o = (state_q == ST_IDLE) && cmd_valid_i;
  assign ram_re    = cmd_pop_o;
  assign ram_we    = (state_q == ST_LOOK) && (op_q == OP_ACCUM);

  always_comb begin
    state_d = state_q;
    valid_d = valid_q;
    max_d   = max_q;
    op_d    = op_q;
    addr_d  = addr_q;
    row_d   = row_q;
    hit_d   = hit_q;
    prod_d  = prod_q;
    rem_d   = rem_q;
    quo_d   = quo_q;
    step_d  = step_q;

    case (state_q)
      ST_IDLE: begin
        if (cmd_valid_i) begin
          op_d    = cmd_i.op;
          addr_d  = cmd_i.addr;
          row_d   = cmd_i.row;
          hit_d   = valid_q[cmd_i.addr];
          state_d = ST_DONE;
          case (cmd_i.op)
            OP_CLEAR: begin
              valid_d = '0;
              max_d   = '0;
            end
            OP_ACCUM, OP_READ: state_d = ST_LOOK;
            default: ;
          endcase
        end
      end
      ST_LOOK: begin
        state_d = ST_DONE;
        if (op_q == OP_ACCUM) begin
          valid_d[addr_q] = 1'b1;
          if (cnt_inc > max_q) begin
            max_d = cnt_inc;
          end
        end else if (max_q == '0) begin
          quo_d = '0;
        end else begin
          prod_d  = ProdW'(cnt) * ProdW'(BAR_SCALE);
          state_d = ST_PREP;
        end
      end
      ST_PREP: begin
        rem_d   = prod_q[ProdW-1:HEIGHT_W];
        quo_d   = prod_q[HEIGHT_W-1:0];
        step_d  = '0;
        state_d = ST_DIV;
      end
      ST_DIV: begin
        rem_d  = rem_ge ? rem_diff[COUNT_BITS-1:0] : rem_sh[COUNT_BITS-1:0];
        quo_d  = {quo_q[HEIGHT_W-2:0], rem_ge};
        step_d = step_q + StepW'(1);
        if (step_q == StepW'(HEIGHT_W - 1)) begin
          state_d = ST_DONE;
        end
      end
      ST_DONE: begin
        if (load_out) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_comb begin
    out_pixel_d  = ((op_q == OP_READ) && !bar) ? bg_q : '0;
    out_height_d = height;
    out_valid_d  = out_valid_q;
    if (load_out) begin
      out_valid_d = 1'b1;
    end else if (out_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      valid_q     <= '0;
      max_q       <= '0;
      bg_q        <= '0;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      valid_q     <= valid_d;
      max_q       <= max_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        bg_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    op_q   <= op_d;
    addr_q <= addr_d;
    row_q  <= row_d;
    hit_q  <= hit_d;
    prod_q <= prod_d;
    rem_q  <= rem_d;
    quo_q  <= quo_d;
    if (load_out) begin
      out_pixel_q  <= out_pixel_d;
      out_height_q <= out_height_d;
    end
  end

  assign out_o.valid      = out_valid_q;
  assign out_o.plot_pixel = out_pixel_q;
  assign out_o.bar_height = out_height_q;

endmodule

`default_nettype wire

>>> rtl/histogram_plot_renderer.sv
// Top level of the histogram plot renderer: front part with command queue,
// back part with bin RAM and divider. Depends on hpr_pkg, hpr_in_if,
// hpr_out_if, hpr_front and hpr_back.
//
//   Channel   Direction  Handshake          Beat contents
//   in_i      in         valid/ready        func, pixel_value, plot_row, plot_col
//   out_o     out        valid/ready        plot_pixel, bar_height
//   cfg       in         cfg_we_i only      cfg_wdata_i = background level
//
// In the back part an accumulate goes through the look-up and done states, a clear
// or unused code straight to done; a read adds a prepare state and the divider,
// one bar-height bit per cycle, except while the histogram is empty.
// The two-entry queue keeps accepting beats while the back part is busy, until it is full.
// Reset clears the bins at once through per-bin valid bits; no clearing pass.
// A stalled output holds its result and the back part waits for it to drain.
`default_nettype none

module histogram_plot_renderer #(
  parameter int unsigned COUNT_BITS = 21
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  hpr_in_if.sink          in_i,
  hpr_out_if.source       out_o,
  input  wire logic       cfg_we_i,
  input  wire logic [7:0] cfg_wdata_i
);
  import hpr_pkg::*;

  cmd_t cmd;
  logic cmd_valid;
  logic cmd_pop;

  hpr_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_i        (in_i),
    .cmd_o       (cmd),
    .cmd_valid_o (cmd_valid),
    .cmd_pop_i   (cmd_pop)
  );

  hpr_back #(
    .COUNT_BITS (COUNT_BITS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .cmd_valid_i (cmd_valid),
    .cmd_pop_o   (cmd_pop),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .out_o       (out_o)
  );

endmodule

`default_nettype wire

>>> rtl/hpr_checker.sv
// Port-level checks for the histogram plot renderer, bound to its top level.
// Depends on histogram_plot_renderer's ports only.
`default_nettype none

module hpr_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [7:0] out_plot_pixel,
  input wire logic [7:0] out_bar_height
);

  // Items accepted whose result has not yet been taken.
  logic [2:0] pending_q;
  logic       in_acc, out_acc;

  assign in_acc  = in_valid && in_ready;
  assign out_acc = out_valid && out_ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else if (in_acc && !out_acc) begin
      pending_q <= pending_q + 3'd1;
    end else if (out_acc && !in_acc) begin
      pending_q <= pending_q - 3'd1;
    end
  end

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid && !out_ready |=> out_valid && $stable(out_plot_pixel) && $stable(out_bar_height))
    else $error("result changed while stalled");

  a_height_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> out_bar_height <= 8'd250)
    else $error("bar height above full scale");

  a_no_invented: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid |-> pending_q != 3'd0)
    else $error("result without an accepted item");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q == 3'd0 |-> in_ready)
    else $error("input stalled with nothing in flight");

  a_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd4)
    else $error("more items in flight than the block can hold");

endmodule

bind histogram_plot_renderer hpr_checker u_hpr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .in_valid       (in_i.valid),
  .in_ready       (in_i.ready),
  .out_valid      (out_o.valid),
  .out_ready      (out_o.ready),
  .out_plot_pixel (out_o.plot_pixel),
  .out_bar_height (out_o.bar_height)
);

`default_nettype wire

>>> tb/tb_histogram_plot_renderer.sv
// Self-checking testbench for histogram_plot_renderer: directed table, then random scenes,
// saturation runs and noise with random idling on both channels, checked beat by beat.
// Depends on hpr_pkg, hpr_in_if, hpr_out_if and the renderer RTL.
module tb_histogram_plot_renderer;
  import hpr_pkg::*;

  // An eight-bit counter width lets bins saturate within a short run.
  localparam int unsigned CNT_W     = 8;
  localparam int unsigned ITEM_GOAL = 1950;
  localparam int unsigned LIMIT     = 600000;
  localparam logic [CNT_W-1:0] CNT_FULL = '1;

  typedef struct packed {
    op_e        op;
    logic [7:0] pix;
    logic [7:0] row;
    logic [7:0] col;
  } px_cmd_t;

  typedef struct packed {
    logic [7:0] pixel;
    logic [7:0] height;
  } plot_res_t;

  // One row of the directed table: either a background write or one beat,
  // with the result typed in where it is obvious.
  typedef struct packed {
    logic       cfg;
    logic [7:0] bg;
    op_e        op;
    logic [7:0] pix;
    logic [7:0] row;
    logic [7:0] col;
    logic       typed;
    logic [7:0] px;
    logic [7:0] ht;
  } dir_row_t;

  localparam int unsigned DIR_ROWS = 26;
  localparam dir_row_t DIR_TABLE [DIR_ROWS] = '{
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0},
    '{1'b1, 8'd255, OP_NONE,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0},
    '{1'b0, 8'd0,   OP_ACCUM, 8'd0,   8'd0,   8'd0,   1'b1, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_ACCUM, 8'd255, 8'd0,   8'd0,   1'b1, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_ACCUM, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_NONE,  8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd255, 8'd255, 1'b1, 8'd0,   8'd250},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd4,   8'd255, 1'b1, 8'd255, 8'd250},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd5,   8'd255, 1'b1, 8'd0,   8'd250},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd0,   8'd0,   1'b1, 8'd255, 8'd125},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd130, 8'd0,   1'b1, 8'd0,   8'd125},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd129, 8'd0,   1'b1, 8'd255, 8'd125},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd255, 8'd128, 1'b1, 8'd255, 8'd0},
    '{1'b0, 8'd0,   OP_CLEAR, 8'd255, 8'd255, 8'd255, 1'b1, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd255, 8'd255, 1'b1, 8'd255, 8'd0},
    '{1'b1, 8'hA5,  OP_NONE,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_ACCUM, 8'h55,  8'd0,   8'd0,   1'b1, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_ACCUM, 8'hAA,  8'd0,   8'd0,   1'b1, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_ACCUM, 8'hAA,  8'd0,   8'd0,   1'b1, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_ACCUM, 8'hAA,  8'd0,   8'd0,   1'b1, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd172, 8'h55,  1'b0, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd171, 8'h55,  1'b0, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd0,   8'hAA,  1'b0, 8'd0,   8'd0},
    '{1'b1, 8'd0,   OP_NONE,  8'd0,   8'd0,   8'd0,   1'b0, 8'd0,   8'd0},
    '{1'b0, 8'd0,   OP_READ,  8'd0,   8'd200, 8'h55,  1'b0, 8'd0,   8'd0}
  };

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       cfg_we_i;
  logic [7:0] cfg_wdata_i;

  hpr_in_if  pix_in ();
  hpr_out_if plot_out ();

  histogram_plot_renderer #(.COUNT_BITS(CNT_W)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (pix_in),
    .out_o      (plot_out),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the block: bin counters, largest bin and background level.
  logic [CNT_W-1:0] bin_cnt [NUM_BINS];
  logic [CNT_W-1:0] peak_cnt;
  logic [7:0]       bg_lvl;

  plot_res_t   plot_due [$];
  bit          calm;
  int unsigned errs;
  int unsigned n_items;
  int unsigned n_op [4];
  int unsigned n_bar;
  int unsigned n_sat;
  int unsigned cyc;

  function automatic logic [7:0] bar_height_of(input logic [7:0] c);
    if (peak_cnt == '0) return 8'd0;
    return 8'((32'(bin_cnt[c]) * 32'(BAR_SCALE)) / 32'(peak_cnt));
  endfunction

  // Applies one accepted beat to the shadow state and returns its result.
  function automatic plot_res_t plot_step(input px_cmd_t c);
    plot_res_t  r;
    logic [7:0] h;
    r = '0;
    n_op[c.op]++;
    case (c.op)
      OP_ACCUM: begin
        if (bin_cnt[c.pix] == CNT_FULL) n_sat++;
        else bin_cnt[c.pix] = bin_cnt[c.pix] + CNT_W'(1);
        if (bin_cnt[c.pix] > peak_cnt) peak_cnt = bin_cnt[c.pix];
      end
      OP_READ: begin
        h = bar_height_of(c.col);
        r.height = h;
        if (h != 8'd0 && 32'(c.row) + 32'(h) >= 32'(PLOT_BOTTOM)) begin
          r.pixel = 8'd0;
          n_bar++;
        end else begin
          r.pixel = bg_lvl;
        end
      end
      OP_CLEAR: begin
        foreach (bin_cnt[i]) bin_cnt[i] = '0;
        peak_cnt = '0;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic px_cmd_t mk_cmd(input op_e op, input logic [7:0] pix,
                                     input logic [7:0] row, input logic [7:0] col);
    px_cmd_t c;
    c.op  = op;
    c.pix = pix;
    c.row = row;
    c.col = col;
    return c;
  endfunction

  // Drives one beat after a random gap, none in the calm phase, and records its result once it is taken.
  task automatic send_cmd(input px_cmd_t c, input bit typed, input plot_res_t typed_res);
    plot_res_t r;
    while (!calm && $urandom_range(99) < 29) begin
      pix_in.valid <= 1'b0;
      @(posedge clk_i);
    end
    pix_in.valid       <= 1'b1;
    pix_in.func        <= c.op;
    pix_in.pixel_value <= c.pix;
    pix_in.plot_row    <= c.row;
    pix_in.plot_col    <= c.col;
    @(posedge clk_i);
    while (!pix_in.ready) @(posedge clk_i);
    r = plot_step(c);
    plot_due.push_back(typed ? typed_res : r);
    n_items++;
  endtask

  task automatic send_any(input op_e op);
    send_cmd(mk_cmd(op, 8'($urandom), 8'($urandom), 8'($urandom)), 1'b0, '0);
  endtask

  // Reads a column, mostly at rows right around the top edge of its bar.
  task automatic send_read(input logic [7:0] col);
    int edge_row;
    edge_row = 255 - int'(bar_height_of(col)) + int'($urandom_range(2)) - 1;
    if (edge_row < 0) edge_row = 0;
    if (edge_row > 255) edge_row = 255;
    if ($urandom_range(99) < 40) edge_row = $urandom_range(255);
    send_cmd(mk_cmd(OP_READ, 8'($urandom), 8'(edge_row), col), 1'b0, '0);
  endtask

  // Background writes only happen with nothing in flight.
  task automatic write_bg(input logic [7:0] v);
    pix_in.valid <= 1'b0;
    while (plot_due.size() != 0) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= v;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    bg_lvl = v;
  endtask

  // A clean frame: clear, a burst of pixels mostly at four hot levels with other commands mixed in, then reads.
  task automatic run_scene();
    logic [7:0] hot [4];
    int         n_acc;
    int         n_rd;
    foreach (hot[i]) hot[i] = 8'($urandom);
    send_any(OP_CLEAR);
    n_acc = $urandom_range(1, 200);
    repeat (n_acc) begin
      if ($urandom_range(99) < 8) send_any(op_e'($urandom_range(3)));
      else if ($urandom_range(99) < 60)
        send_cmd(mk_cmd(OP_ACCUM, hot[2'($urandom_range(3))], 8'($urandom),
                        8'($urandom)), 1'b0, '0);
      else send_any(OP_ACCUM);
    end
    n_rd = $urandom_range(16, 64);
    repeat (n_rd) begin
      if ($urandom_range(99) < 50) send_read(hot[2'($urandom_range(3))]);
      else send_read(8'($urandom));
    end
  endtask

  // Aims just over a full count of accumulates at one bin, some going to random bins, then reads it and its neighbors.
  task automatic run_saturation();
    logic [7:0] p;
    int         n_acc;
    p = 8'($urandom);
    n_acc = int'(CNT_FULL) + 1 + $urandom_range(8);
    repeat (n_acc) begin
      if ($urandom_range(99) < 5) send_any(OP_ACCUM);
      else send_cmd(mk_cmd(OP_ACCUM, p, 8'($urandom), 8'($urandom)), 1'b0, '0);
    end
    repeat ($urandom_range(12, 30)) begin
      if ($urandom_range(99) < 50) send_read(p);
      else send_read(p + 8'($urandom_range(2)) - 8'd1);
    end
  endtask

  task automatic run_noise();
    repeat ($urandom_range(20, 40)) send_any(op_e'($urandom_range(3)));
  endtask

  always @(posedge clk_i) begin : result_check
    plot_res_t w;
    if (rst_ni && plot_out.valid && plot_out.ready) begin
      if (plot_due.size() == 0) begin
        $display("%0t: unexpected result, pixel %0d height %0d", $time,
                 plot_out.plot_pixel, plot_out.bar_height);
        errs++;
      end else begin
        w = plot_due.pop_front();
        if (plot_out.plot_pixel !== w.pixel) begin
          $display("%0t: plot_pixel expected %0d, got %0d", $time, w.pixel,
                   plot_out.plot_pixel);
          errs++;
        end
        if (plot_out.bar_height !== w.height) begin
          $display("%0t: bar_height expected %0d, got %0d", $time, w.height,
                   plot_out.bar_height);
          errs++;
        end
      end
    end
  end

  initial begin
    plot_out.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      plot_out.ready <= calm || ($urandom_range(99) >= 29);
    end
  end

  always @(posedge clk_i) cyc <= cyc + 1;

  initial begin
    wait (cyc >= LIMIT);
    $display("%0t: run did not finish in %0d cycles", $time, LIMIT);
    $display("[histogram_plot_renderer] ERROR");
    $finish;
  end

  initial begin : stimulus
    int unsigned n_dir;
    int unsigned phase;
    int unsigned kind;
    logic [7:0]  bg_pick [6];
    plot_res_t   typed_res;
    dir_row_t    d;
    bg_pick = '{8'd0, 8'd255, 8'h5A, 8'h01, 8'hFE, 8'h80};
    foreach (bin_cnt[i]) bin_cnt[i] = '0;
    peak_cnt = '0;
    bg_lvl   = 8'd0;
    pix_in.valid       <= 1'b0;
    pix_in.func        <= FUNC_ACCUM;
    pix_in.pixel_value <= 8'd0;
    pix_in.plot_row    <= 8'd0;
    pix_in.plot_col    <= 8'd0;
    cfg_we_i           <= 1'b0;
    cfg_wdata_i        <= 8'd0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (int i = 0; i < DIR_ROWS; i++) begin
      d = DIR_TABLE[5'(i)];
      if (d.cfg) begin
        write_bg(d.bg);
      end else begin
        typed_res.pixel  = d.px;
        typed_res.height = d.ht;
        send_cmd(mk_cmd(d.op, d.pix, d.row, d.col), d.typed, typed_res);
      end
    end
    n_dir = n_items;

    phase = 0;
    while (n_items - n_dir < ITEM_GOAL) begin
      phase++;
      if (phase < 6) write_bg(bg_pick[3'(phase)]);
      else write_bg(8'($urandom));
      // One whole phase runs with both sides flat out.
      calm = (phase == 4);
      kind = $urandom_range(99);
      if (phase == 2 || kind < 12) run_saturation();
      else if (kind < 25) run_noise();
      else run_scene();
    end
    calm = 1'b0;

    pix_in.valid <= 1'b0;
    while (plot_due.size() != 0) @(posedge clk_i);
    repeat (24) @(posedge clk_i);
    if (plot_due.size() != 0) begin
      $display("%0t: %0d results never arrived", $time, plot_due.size());
      errs++;
    end
    $display("Sent %0d beats in %0d phases: %0d accumulate, %0d read, %0d clear, %0d unused.",
             n_items, phase, n_op[OP_ACCUM], n_op[OP_READ], n_op[OP_CLEAR], n_op[OP_NONE]);
    $display("Reads landing on a bar: %0d; accumulates into a full bin: %0d; errors: %0d.",
             n_bar, n_sat, errs);
    if (errs == 0) $display("[histogram_plot_renderer] OK");
    else $display("[histogram_plot_renderer] ERROR");
    $finish;
  end

endmodule

>>> filelist.f
rtl/hpr_pkg.sv
rtl/hpr_in_if.sv
rtl/hpr_out_if.sv
rtl/hpr_ram.sv
rtl/hpr_front.sv
rtl/hpr_back.sv
rtl/histogram_plot_renderer.sv
rtl/hpr_checker.sv
tb/tb_histogram_plot_renderer.sv
